>>> design/twsm_pkg.sv
package twsm_pkg;

    // Longest read burst, in bytes
    localparam int BURST_MAX = 64;

    // Field widths
    localparam int ADDR_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int KIND_W  = 2;

    // Stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Command codes carried in the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_SPARE = 2'd3
    } t_kind;

    // One result beat
    typedef struct packed {
        logic              busy_res;
        logic              last_byte;
        logic              byte_valid;
        logic [BYTE_W-1:0] read_byte;
        logic              sda_drive;
        logic              sda_out;
        logic              scl_level;
        logic              cs_active;
    } t_result;

endpackage

>>> design/three_wire_serial_master.sv
// Three-wire half-duplex serial master. Each input beat is one tick of the bit
// timing and yields exactly one result beat with the pin levels for that tick;
// the block takes one beat per clock cycle while at most one result waits in
// its two-entry output stage. kind 1 starts a write (address with
// bit 7 set, then one data byte), kind 2 starts a read (address with bit 7
// clear, then read_count bytes gathered, 0 taken as 1 and counts above
// BURST_MAX clamped to it); starts arriving while busy are treated as plain
// ticks. Every bit spends half_period ticks low (data changes) and half_period
// ticks high, with read data sampled on the last high tick; half_period 0 acts
// as 1. Write half_period (APB address 0) only while the block is idle.
module three_wire_serial_master (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // s_axis tdata: reg_address[6:0], write_data[14:7], read_count[21:15],
    // sda_in[22], zero[23]
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [twsm_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // s_axis tuser: kind[1:0]
    input  logic [twsm_pkg::KIND_W-1:0]        i_s_axis_tuser,
    // m_axis tdata: cs_active[0], scl_level[1], sda_out[2], sda_drive[3],
    // read_byte[11:4], busy_res[12], zero[15:13]
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [twsm_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // m_axis tuser: byte_valid[0]
    output logic                               o_m_axis_tuser,
    // m_axis tlast: last_byte
    output logic                               o_m_axis_tlast,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [2:0]                         i_paddr,
    input  logic [31:0]                        i_pwdata,
    output logic [31:0]                        o_prdata,
    output logic                               o_pready
);
    import twsm_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ADDR  = 2'd1,
        PH_WDATA = 2'd2,
        PH_RDATA = 2'd3
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_is_read, n_is_read;
    logic [2:0]         r_bit_counter, n_bit_counter;
    logic [COUNT_W-1:0] r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0]  r_shift_reg, n_shift_reg;
    logic [BYTE_W-1:0]  r_pending, n_pending;
    logic [7:0]         r_tick_div, n_tick_div;
    logic               r_clock_high, n_clock_high;
    logic [7:0]         r_half_period;

    logic               r_out_valid, r_skid_valid;
    t_result            r_out, r_skid, n_result;

    logic               in_beat, out_beat, cfg_write;
    t_kind              in_kind;
    logic [ADDR_W-1:0]  in_addr;
    logic [BYTE_W-1:0]  in_wdata;
    logic [COUNT_W-1:0] in_count, clamped_count;
    logic               in_sda;
    logic [7:0]         eff_half;
    logic [8:0]         tick_sum;
    logic               drive;

    // Unpack the input beat
    assign in_kind  = t_kind'(i_s_axis_tuser);
    assign in_addr  = i_s_axis_tdata[6:0];
    assign in_wdata = i_s_axis_tdata[14:7];
    assign in_count = i_s_axis_tdata[21:15];
    assign in_sda   = i_s_axis_tdata[22];

    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_beat = r_out_valid && i_m_axis_tready;
    assign o_s_axis_tready = !r_skid_valid;

    // Configuration port
    assign o_pready  = 1'b1;
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata  = (i_paddr[2] == 1'b0) ? {24'd0, r_half_period} : 32'd0;

    assign eff_half = (r_half_period == 8'd0) ? 8'd1 : r_half_period;

    // Clamp the read length into one to BURST_MAX
    always_comb begin
        clamped_count = in_count;
        if (in_count == '0)
            clamped_count = COUNT_W'(1);
        else if (in_count > COUNT_W'(BURST_MAX))
            clamped_count = COUNT_W'(BURST_MAX);
    end

    // Advance the transaction by one tick and form its result
    always_comb begin
        n_phase       = r_phase;
        n_is_read     = r_is_read;
        n_bit_counter = r_bit_counter;
        n_bytes_left  = r_bytes_left;
        n_shift_reg   = r_shift_reg;
        n_pending     = r_pending;
        n_tick_div    = r_tick_div;
        n_clock_high  = r_clock_high;
        n_result      = '0;
        drive         = 1'b0;
        tick_sum      = '0;

        // Take a start only while idle
        if (r_phase == PH_IDLE && (in_kind == KIND_WRITE || in_kind == KIND_READ)) begin
            n_is_read     = (in_kind == KIND_READ);
            n_shift_reg   = (in_kind == KIND_READ) ? {1'b0, in_addr} : {1'b1, in_addr};
            n_pending     = in_wdata;
            n_bytes_left  = clamped_count;
            n_phase       = PH_ADDR;
            n_clock_high  = 1'b0;
            n_tick_div    = '0;
            n_bit_counter = '0;
        end

        if (n_phase == PH_IDLE) begin
            n_result.scl_level = 1'b1;
        end else begin
            drive               = (n_phase != PH_RDATA);
            n_result.cs_active  = 1'b1;
            n_result.scl_level  = n_clock_high;
            n_result.sda_out    = drive & n_shift_reg[BYTE_W-1];
            n_result.sda_drive  = drive;
            n_result.busy_res   = 1'b1;

            tick_sum = {1'b0, n_tick_div} + 9'd1;
            if (tick_sum >= {1'b0, eff_half}) begin
                n_tick_div = '0;
                if (!n_clock_high) begin
                    n_clock_high = 1'b1;
                end else begin
                    // End of the high half: shift, sample on reads
                    n_clock_high  = 1'b0;
                    n_shift_reg   = (n_phase == PH_RDATA) ? {n_shift_reg[BYTE_W-2:0], in_sda}
                                                          : {n_shift_reg[BYTE_W-2:0], 1'b0};
                    n_bit_counter = n_bit_counter + 3'd1;
                    if (n_bit_counter == 3'd0) begin
                        case (n_phase)
                            PH_ADDR: begin
                                if (n_is_read) begin
                                    n_phase     = PH_RDATA;
                                    n_shift_reg = '0;
                                end else begin
                                    n_phase     = PH_WDATA;
                                    n_shift_reg = n_pending;
                                end
                            end
                            PH_WDATA: begin
                                n_phase      = PH_IDLE;
                                n_clock_high = 1'b1;
                            end
                            PH_RDATA: begin
                                n_result.byte_valid = 1'b1;
                                n_result.read_byte  = n_shift_reg;
                                if (n_bytes_left != '0)
                                    n_bytes_left = n_bytes_left - COUNT_W'(1);
                                if (n_bytes_left == '0) begin
                                    n_result.last_byte = 1'b1;
                                    n_phase            = PH_IDLE;
                                    n_clock_high       = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end else begin
                n_tick_div = tick_sum[7:0];
            end
        end
    end

    // Hold transaction state and the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_is_read     <= 1'b0;
            r_bit_counter <= '0;
            r_bytes_left  <= '0;
            r_shift_reg   <= '0;
            r_pending     <= '0;
            r_tick_div    <= '0;
            r_clock_high  <= 1'b1;
            r_half_period <= 8'd1;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (cfg_write && i_paddr[2] == 1'b0)
                r_half_period <= i_pwdata[7:0];

            if (in_beat) begin
                r_phase       <= n_phase;
                r_is_read     <= n_is_read;
                r_bit_counter <= n_bit_counter;
                r_bytes_left  <= n_bytes_left;
                r_shift_reg   <= n_shift_reg;
                r_pending     <= n_pending;
                r_tick_div    <= n_tick_div;
                r_clock_high  <= n_clock_high;
            end

            // Output register with a skid entry behind it
            if (!r_out_valid || out_beat) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out       <= n_result;
                    r_out_valid <= in_beat;
                end
            end else if (in_beat) begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Pack the result beat
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.busy_res, r_out.read_byte, r_out.sda_drive,
                              r_out.sda_out, r_out.scl_level, r_out.cs_active};
    assign o_m_axis_tuser  = r_out.byte_valid;
    assign o_m_axis_tlast  = r_out.last_byte;

    // A skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    // A start taken while idle leaves the block busy
    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && r_phase == PH_IDLE && (in_kind == KIND_WRITE || in_kind == KIND_READ))
        |=> (r_phase != PH_IDLE || r_skid_valid || r_out.busy_res))
        else $error("start did not begin a transaction");

    // Last-byte flag only on a received byte
    a_last_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser)
        else $error("last flag without a received byte");

    // Data line released means no driven level
    a_released_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[3]) |-> !o_m_axis_tdata[2])
        else $error("data level shown while line released");

endmodule
